/* design/bmsp_pkg.sv */
// Package for the Bayer mosaic unit with symmetric padding.
// Holds field widths, command and site codes, configuration register indexes,
// and the control state type. No dependencies.
package bmsp_pkg;

  // Fixed field widths.
  localparam int COORD_W = 10;  // output coordinate of a fetch
  localparam int LOAD_W  = 8;   // source coordinate of a load
  localparam int CH_W    = 8;   // one color sample
  localparam int SIZE_W  = 9;   // source width and height registers
  localparam int PAD_W   = 8;   // padding register
  localparam int OFF_W   = 9;   // padding plus the extra row or column
  localparam int PIX_W   = 3 * CH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Command codes carried on func.
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  // Filter color of a site.
  typedef enum logic [1:0] {
    SITE_GREEN = 2'd0,
    SITE_RED   = 2'd1,
    SITE_BLUE  = 2'd2
  } site_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH      = 3'd0,
    CFG_SRC_HEIGHT     = 3'd1,
    CFG_RED_COL        = 3'd2,
    CFG_RED_ROW        = 3'd3,
    CFG_FLATTEN_MODE   = 3'd4,
    CFG_PAD_AMOUNT     = 3'd5,
    CFG_EXTRA_TOP_ROW  = 3'd6,
    CFG_EXTRA_LEFT_COL = 3'd7
  } cfg_idx_t;

  // Control sequence of a fetch.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

/* design/bayer_mosaic_symmetric_pad_unit.sv */
// Top level of the Bayer mosaic unit with symmetric padding.
// Holds the image store, the configuration registers and the fetch sequencer.
// Depends on bmsp_pkg and bmsp_fold.
//
// A load item is written to the image store at the edge that accepts it, so
// loads go in one per cycle while no fetch is in progress, and busy stays low.
// A fetch item passes through the two fold units (ten remainder steps and one
// mirror step, column and row in parallel), then the address hand-over, the
// store read and the result register, before the block accepts the next item.
// The result shows on the outputs for one cycle with result_valid high; the
// receiver cannot stall it, and the next item may be accepted in that same
// cycle. The store has one port, used by loads only while idle and by fetches
// only in their read cycle. Entries are undefined after reset until loaded; a
// fetch must only reach loaded pixels. Configuration is to be written while
// idle; the block itself does not enforce this, and cfg_ready is always high.
module bayer_mosaic_symmetric_pad_unit #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [bmsp_pkg::LOAD_W-1:0]     load_col,
  input  logic [bmsp_pkg::LOAD_W-1:0]     load_row,
  input  logic [bmsp_pkg::CH_W-1:0]       red_in,
  input  logic [bmsp_pkg::CH_W-1:0]       green_in,
  input  logic [bmsp_pkg::CH_W-1:0]       blue_in,
  input  logic [bmsp_pkg::COORD_W-1:0]    out_col,
  input  logic [bmsp_pkg::COORD_W-1:0]    out_row,
  output logic                            result_valid,
  output logic [bmsp_pkg::CH_W-1:0]       red_out,
  output logic [bmsp_pkg::CH_W-1:0]       green_out,
  output logic [bmsp_pkg::CH_W-1:0]       blue_out,
  output logic [1:0]                      site_color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmsp_pkg::*;

  localparam int WLEN_W = $clog2(MAX_WIDTH + 1);
  localparam int HLEN_W = $clog2(MAX_HEIGHT + 1);
  localparam int X_W = $clog2(MAX_WIDTH);
  localparam int Y_W = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers.
  logic [SIZE_W-1:0] src_width;
  logic [SIZE_W-1:0] src_height;
  logic              red_col;
  logic              red_row;
  logic              flatten_mode;
  logic [PAD_W-1:0]  pad_amount;
  logic              extra_top_row;
  logic              extra_left_col;

  state_t state;
  state_t state_next;

  logic              accept;
  logic              load_en;
  logic              fetch_go;
  logic              mem_rd;
  logic              emit;
  logic              col_par;
  logic              row_par;
  logic [WLEN_W-1:0] w_len;
  logic [HLEN_W-1:0] h_len;
  logic [OFF_W-1:0]  x_off;
  logic [OFF_W-1:0]  y_off;
  logic              x_done;
  logic              y_done;
  logic [X_W-1:0]    x_pos;
  logic [Y_W-1:0]    y_pos;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rd_data;
  logic [CH_W-1:0]   pix_r;
  logic [CH_W-1:0]   pix_g;
  logic [CH_W-1:0]   pix_b;
  logic              green_par;
  site_t             site;
  logic [CH_W-1:0]   kept;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= SIZE_W'(256);
      src_height <= SIZE_W'(256);
      red_col <= 1'b0;
      red_row <= 1'b0;
      flatten_mode <= 1'b0;
      pad_amount <= '0;
      extra_top_row <= 1'b0;
      extra_left_col <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:      src_width <= cfg_data;
        CFG_SRC_HEIGHT:     src_height <= cfg_data;
        CFG_RED_COL:        red_col <= cfg_data[0];
        CFG_RED_ROW:        red_row <= cfg_data[0];
        CFG_FLATTEN_MODE:   flatten_mode <= cfg_data[0];
        CFG_PAD_AMOUNT:     pad_amount <= cfg_data[PAD_W-1:0];
        CFG_EXTRA_TOP_ROW:  extra_top_row <= cfg_data[0];
        CFG_EXTRA_LEFT_COL: extra_left_col <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Source size saturated to at least 2 and at most what the store can hold, and the padding offsets.
  always_comb begin
    if (32'(src_width) > 32'(MAX_WIDTH)) begin
      w_len = WLEN_W'(MAX_WIDTH);
    end else if (src_width < SIZE_W'(2)) begin
      w_len = WLEN_W'(2);
    end else begin
      w_len = WLEN_W'(src_width);
    end
    if (32'(src_height) > 32'(MAX_HEIGHT)) begin
      h_len = HLEN_W'(MAX_HEIGHT);
    end else if (src_height < SIZE_W'(2)) begin
      h_len = HLEN_W'(2);
    end else begin
      h_len = HLEN_W'(src_height);
    end
    x_off = OFF_W'(pad_amount) + OFF_W'(extra_left_col);
    y_off = OFF_W'(pad_amount) + OFF_W'(extra_top_row);
  end

  // Fetch sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && func == FUNC_FETCH) state_next = ST_FOLD;
      ST_FOLD: if (x_done) state_next = ST_READ;
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Fetch sequencer: outputs.
  always_comb begin
    busy = 1'b1;
    mem_rd = 1'b0;
    emit = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_FOLD: ;
      ST_READ: mem_rd = 1'b1;
      ST_EMIT: emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign load_en = accept && func == FUNC_LOAD &&
                   32'(load_col) < 32'(MAX_WIDTH) && 32'(load_row) < 32'(MAX_HEIGHT);
  assign fetch_go = accept && func == FUNC_FETCH;

  // Site parity of the requested output pixel.
  always_ff @(posedge clk) begin
    if (fetch_go) begin
      col_par <= out_col[0];
      row_par <= out_row[0];
    end
  end

  // Column and row folds run side by side.
  bmsp_fold #(.MAX_LEN(MAX_WIDTH)) u_fold_x (
    .clk    (clk),
    .rst    (rst),
    .start  (fetch_go),
    .coord  (out_col),
    .offset (x_off),
    .len    (w_len),
    .done   (x_done),
    .pos    (x_pos)
  );

  bmsp_fold #(.MAX_LEN(MAX_HEIGHT)) u_fold_y (
    .clk    (clk),
    .rst    (rst),
    .start  (fetch_go),
    .coord  (out_row),
    .offset (y_off),
    .len    (h_len),
    .done   (y_done),
    .pos    (y_pos)
  );

  // One store port: the fetch address in the read cycle, the load address otherwise.
  always_comb begin
    if (mem_rd) begin
      mem_addr = ADDR_W'(32'(y_pos) * MAX_WIDTH + 32'(x_pos));
    end else begin
      mem_addr = ADDR_W'(32'(load_row) * MAX_WIDTH + 32'(load_col));
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[mem_addr] <= {blue_in, green_in, red_in};
    end
    if (mem_rd) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Classify the site and keep its channel.
  always_comb begin
    pix_r = rd_data[CH_W-1:0];
    pix_g = rd_data[2*CH_W-1:CH_W];
    pix_b = rd_data[3*CH_W-1:2*CH_W];
    green_par = ~(red_col ^ red_row);
    if ((col_par ^ row_par) == green_par) begin
      site = SITE_GREEN;
      kept = pix_g;
    end else if (row_par == red_row) begin
      site = SITE_RED;
      kept = pix_r;
    end else begin
      site = SITE_BLUE;
      kept = pix_b;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      site_color <= site;
      if (flatten_mode) begin
        red_out <= kept;
        green_out <= kept;
        blue_out <= kept;
      end else begin
        red_out <= (site == SITE_RED) ? pix_r : '0;
        green_out <= (site == SITE_GREEN) ? pix_g : '0;
        blue_out <= (site == SITE_BLUE) ? pix_b : '0;
      end
    end
  end

  // The two fold units must finish together.
  a_fold_lockstep: assert property (@(posedge clk) disable iff (rst)
    x_done == y_done)
    else $error("column and row folds out of step");

  // A fetch makes the block busy on the next cycle.
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    fetch_go |=> busy)
    else $error("fetch accepted but block not busy");

  // A load never occupies the sequencer.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_LOAD) |=> !busy)
    else $error("load item made the block busy");

  // Every emit cycle yields exactly one strobed result.
  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    emit |=> (result_valid && !busy))
    else $error("result not strobed after emit");

  // A result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

endmodule

/* design/bmsp_fold.sv */
// Symmetric fold of one coordinate into 0..len-1 with period 2*len-2.
// Iterative restoring remainder, one compare and subtract per cycle.
// Depends on bmsp_pkg.
module bmsp_fold #(
  parameter int MAX_LEN = 256,
  localparam int LEN_W = $clog2(MAX_LEN + 1),
  localparam int RES_W = $clog2(MAX_LEN)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bmsp_pkg::COORD_W-1:0] coord,
  input  logic [bmsp_pkg::OFF_W-1:0]   offset,
  input  logic [LEN_W-1:0]         len,
  output logic                     done,
  output logic [RES_W-1:0]         pos
);
  import bmsp_pkg::*;

  localparam int PER_W = LEN_W + 1;
  localparam int DIV_W = PER_W + COORD_W - 1;
  localparam int CNT_W = $clog2(COORD_W + 1);

  logic [PER_W-1:0]       period;
  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0]     mag;
  logic [COORD_W-1:0]     rem;
  logic [DIV_W-1:0]       div;
  logic [CNT_W-1:0]       cnt;
  logic                   running;
  logic [DIV_W-1:0]       rem_wide;
  logic [DIV_W-1:0]       mirror;

  // Period of the reflection and magnitude of the shifted coordinate.
  always_comb begin
    period = {len, 1'b0} - PER_W'(2);
    diff = $signed({1'b0, coord}) - $signed({{(COORD_W + 1 - OFF_W){1'b0}}, offset});
    mag = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
    rem_wide = DIV_W'(rem);
    mirror = DIV_W'(period) - rem_wide;
  end

  // Remainder by shifted divisor, then the mirror step on the last cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= '0;
        rem <= mag;
        div <= DIV_W'(period) << (COORD_W - 1);
      end else if (running) begin
        if (cnt == CNT_W'(COORD_W)) begin
          running <= 1'b0;
          done <= 1'b1;
          if (rem_wide >= DIV_W'(len)) begin
            pos <= RES_W'(mirror);
          end else begin
            pos <= RES_W'(rem_wide);
          end
        end else begin
          if (rem_wide >= div) begin
            rem <= COORD_W'(rem_wide - div);
          end
          div <= div >> 1;
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

endmodule

/* tb/tb_bayer_mosaic_symmetric_pad_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bayer_mosaic_symmetric_pad_unit.
// Loads source pixels, fetches padded Bayer sites and checks them against a
// class that tracks the image store. Depends on bmsp_pkg and the unit's RTL.
module tb_bayer_mosaic_symmetric_pad_unit;
  import bmsp_pkg::*;

  localparam int MAX_W          = 256;
  localparam int MAX_H          = 256;
  localparam int MAX_COORD      = 1023;
  localparam int RESET_CYCLES   = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 190;

  // One expected output pixel.
  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    site_t           site;
  } mosaic_pixel_t;

  // One full register setting.
  typedef struct {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    bit                red_col;
    bit                red_row;
    bit                flatten;
    logic [PAD_W-1:0]  pad;
    bit                top;
    bit                left;
  } mosaic_setting_t;

  // Tracks the registers and the image store, and predicts every fetch.
  class mosaic_tracker;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    bit                red_col_reg;
    bit                red_row_reg;
    bit                flatten_reg;
    logic [PAD_W-1:0]  pad_reg;
    bit                top_reg;
    bit                left_reg;
    logic [PIX_W-1:0]  pixels [MAX_W*MAX_H];
    mosaic_pixel_t     pending_pixels [$];
    int                mismatches;

    function new();
      width_reg   = SIZE_W'(MAX_W);
      height_reg  = SIZE_W'(MAX_H);
      red_col_reg = 1'b0;
      red_row_reg = 1'b0;
      flatten_reg = 1'b0;
      pad_reg     = '0;
      top_reg     = 1'b0;
      left_reg    = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SRC_WIDTH:      width_reg = data;
        CFG_SRC_HEIGHT:     height_reg = data;
        CFG_RED_COL:        red_col_reg = data[0];
        CFG_RED_ROW:        red_row_reg = data[0];
        CFG_FLATTEN_MODE:   flatten_reg = data[0];
        CFG_PAD_AMOUNT:     pad_reg = data[PAD_W-1:0];
        CFG_EXTRA_TOP_ROW:  top_reg = data[0];
        CFG_EXTRA_LEFT_COL: left_reg = data[0];
        default: ;
      endcase
    endfunction

    // Sizes outside the legal range saturate.
    function int clamp_size(logic [SIZE_W-1:0] v, int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return int'(v);
    endfunction

    // Whole-sample symmetric reflection into 0..len-1.
    function int fold(int len, int n);
      int period;
      int m;
      period = 2 * len - 2;
      m = (n < 0) ? -n : n;
      m = m % period;
      if (m >= len) m = period - m;
      return m;
    endfunction

    function int source_col(logic [COORD_W-1:0] oc);
      return fold(clamp_size(width_reg, MAX_W), int'(oc) - int'(pad_reg) - int'(left_reg));
    endfunction

    function int source_row(logic [COORD_W-1:0] orow);
      return fold(clamp_size(height_reg, MAX_H), int'(orow) - int'(pad_reg) - int'(top_reg));
    endfunction

    // A load updates the store; a fetch queues the mosaiced pixel it must return.
    function void apply_item(func_t f, logic [LOAD_W-1:0] lc, logic [LOAD_W-1:0] lr,
                             logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                             logic [COORD_W-1:0] oc, logic [COORD_W-1:0] orow);
      logic [PIX_W-1:0] px;
      logic [CH_W-1:0]  kept;
      bit               green_par;
      mosaic_pixel_t    p;
      if (f == FUNC_LOAD) begin
        pixels[{lr, lc}] = {b, g, r};
      end else begin
        px = pixels[source_row(orow) * MAX_W + source_col(oc)];
        green_par = ~(red_col_reg ^ red_row_reg);
        if ((oc[0] ^ orow[0]) == green_par) begin
          p.site = SITE_GREEN;
          kept = px[15:8];
        end else if (orow[0] == red_row_reg) begin
          p.site = SITE_RED;
          kept = px[7:0];
        end else begin
          p.site = SITE_BLUE;
          kept = px[23:16];
        end
        if (flatten_reg) begin
          p.red   = kept;
          p.green = kept;
          p.blue  = kept;
        end else begin
          p.red   = (p.site == SITE_RED) ? px[7:0] : '0;
          p.green = (p.site == SITE_GREEN) ? px[15:8] : '0;
          p.blue  = (p.site == SITE_BLUE) ? px[23:16] : '0;
        end
        pending_pixels.push_back(p);
      end
    endfunction

    function void compare(string field, logic [CH_W-1:0] exp_v, logic [CH_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                              logic [1:0] site);
      mosaic_pixel_t p;
      if (pending_pixels.size() == 0) begin
        $error("result_valid with no fetch outstanding");
        mismatches++;
      end else begin
        p = pending_pixels.pop_front();
        compare("red_out", p.red, r);
        compare("green_out", p.green, g);
        compare("blue_out", p.blue, b);
        compare("site_color", CH_W'(p.site), CH_W'(site));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  func_t              func = FUNC_LOAD;
  logic [LOAD_W-1:0]  load_col = '0;
  logic [LOAD_W-1:0]  load_row = '0;
  logic [CH_W-1:0]    red_in = '0;
  logic [CH_W-1:0]    green_in = '0;
  logic [CH_W-1:0]    blue_in = '0;
  logic [COORD_W-1:0] out_col = '0;
  logic [COORD_W-1:0] out_row = '0;
  logic               result_valid;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;
  logic [1:0]         site_color;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mosaic_tracker sb;
  bit            loaded [MAX_W*MAX_H];
  bit            start_on = 1'b0;
  int            burst_left = 0;
  int            items_sent = 0;
  int            idle_cycles = 0;

  bayer_mosaic_symmetric_pad_unit #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .load_col(load_col),
    .load_row(load_row),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .out_col(out_col),
    .out_row(out_row),
    .result_valid(result_valid),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .site_color(site_color),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Watch every handshake; the result is checked before a new item is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid === 1'b1)
        sb.check_pixel(red_out, green_out, blue_out, site_color);
      if (start && !busy)
        sb.apply_item(func, load_col, load_row, red_in, green_in, blue_in, out_col, out_row);
      if (cfg_valid && cfg_ready)
        sb.set_reg(cfg_index, cfg_data);
      if ((start && !busy) || result_valid === 1'b1 || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item and wait until it is taken; gaps come between random bursts.
  task automatic issue(input func_t f, input logic [LOAD_W-1:0] lc, input logic [LOAD_W-1:0] lr,
                       input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                       input logic [CH_W-1:0] b, input logic [COORD_W-1:0] oc,
                       input logic [COORD_W-1:0] orow);
    start    <= 1'b1;
    start_on = 1'b1;
    func     <= f;
    load_col <= lc;
    load_row <= lr;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    out_col  <= oc;
    out_row  <= orow;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start    <= 1'b0;
      start_on = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic load_pixel(input logic [LOAD_W-1:0] lc, input logic [LOAD_W-1:0] lr,
                            input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    issue(FUNC_LOAD, lc, lr, r, g, b, COORD_W'($urandom), COORD_W'($urandom));
    loaded[{lr, lc}] = 1'b1;
  endtask

  // A fetch must only reach loaded pixels, so its source is loaded first if needed.
  task automatic fetch_pixel(input logic [COORD_W-1:0] oc, input logic [COORD_W-1:0] orow);
    int sx;
    int sy;
    sx = sb.source_col(oc);
    sy = sb.source_row(orow);
    if (!loaded[sy * MAX_W + sx])
      load_pixel(LOAD_W'(sx), LOAD_W'(sy), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    issue(FUNC_FETCH, LOAD_W'($urandom), LOAD_W'($urandom), CH_W'($urandom),
          CH_W'($urandom), CH_W'($urandom), oc, orow);
  endtask

  // Drop start, wait for every fetch to return, then let the pipeline drain.
  task automatic settle();
    if (start_on) begin
      start    <= 1'b0;
      start_on = 1'b0;
    end
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Single-bit registers get random upper bits, which the block must ignore.
  function automatic logic [CFG_DATA_W-1:0] flag_word(bit v);
    return (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(v);
  endfunction

  task automatic apply_setting(input mosaic_setting_t s);
    write_reg(CFG_SRC_WIDTH, s.width);
    write_reg(CFG_SRC_HEIGHT, s.height);
    write_reg(CFG_RED_COL, flag_word(s.red_col));
    write_reg(CFG_RED_ROW, flag_word(s.red_row));
    write_reg(CFG_FLATTEN_MODE, flag_word(s.flatten));
    write_reg(CFG_PAD_AMOUNT, {1'($urandom), s.pad});
    write_reg(CFG_EXTRA_TOP_ROW, flag_word(s.top));
    write_reg(CFG_EXTRA_LEFT_COL, flag_word(s.left));
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // The first phases hit the extremes and the saturating sizes; the rest are
  // random, mostly with small images and, about half the time, little padding.
  function automatic mosaic_setting_t phase_setting(int p);
    mosaic_setting_t s;
    case (p)
      0: s = '{9'd2, 9'd2, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 1'b1};
      1: s = '{9'd256, 9'd256, 1'b1, 1'b1, 1'b1, 8'd255, 1'b1, 1'b1};
      2: s = '{9'd0, 9'd1, 1'b1, 1'b0, 1'b1, 8'd3, 1'b0, 1'b0};
      3: s = '{9'd511, 9'd257, 1'b0, 1'b0, 1'b0, 8'd255, 1'b1, 1'b0};
      default: begin
        s.width   = ($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(2, 20))
                                                 : SIZE_W'($urandom_range(0, 511));
        s.height  = ($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(2, 20))
                                                 : SIZE_W'($urandom_range(0, 511));
        s.red_col = 1'($urandom_range(0, 1));
        s.red_row = 1'($urandom_range(0, 1));
        s.flatten = 1'($urandom_range(0, 1));
        s.pad     = ($urandom_range(0, 1) != 0) ? PAD_W'($urandom_range(0, 8))
                                                 : PAD_W'($urandom_range(0, 255));
        s.top     = 1'($urandom_range(0, 1));
        s.left    = 1'($urandom_range(0, 1));
      end
    endcase
    return s;
  endfunction

  // Random mix of loads and fetches; most fetches land inside the padded image.
  task automatic run_phase(input int n_items);
    int first;
    int w;
    int h;
    int span_c;
    int span_r;
    first  = items_sent;
    w      = sb.clamp_size(sb.width_reg, MAX_W);
    h      = sb.clamp_size(sb.height_reg, MAX_H);
    span_c = w + 2 * int'(sb.pad_reg) + int'(sb.left_reg) - 1;
    span_r = h + 2 * int'(sb.pad_reg) + int'(sb.top_reg) - 1;
    if (span_c > MAX_COORD) span_c = MAX_COORD;
    if (span_r > MAX_COORD) span_r = MAX_COORD;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 3) != 0)
          fetch_pixel(COORD_W'($urandom_range(0, span_c)), COORD_W'($urandom_range(0, span_r)));
        else
          fetch_pixel(COORD_W'($urandom), COORD_W'($urandom));
      end else if ($urandom_range(0, 1) != 0) begin
        load_pixel(LOAD_W'($urandom_range(0, w - 1)), LOAD_W'($urandom_range(0, h - 1)),
                   CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      end else begin
        load_pixel(LOAD_W'($urandom), LOAD_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                   CH_W'($urandom));
      end
    end
  endtask

  // Directed items under the reset setting: corner loads with extreme samples,
  // all three site colors, reflection past the edge and periodic wrap.
  task automatic directed_items();
    load_pixel(8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    load_pixel(8'd1, 8'd0, 8'h01, 8'h80, 8'hFE);
    load_pixel(8'd0, 8'd1, 8'hAA, 8'h55, 8'h0F);
    load_pixel(8'd1, 8'd1, 8'h00, 8'h00, 8'h00);
    load_pixel(8'd255, 8'd255, 8'hFF, 8'h00, 8'hFF);
    load_pixel(8'd255, 8'd0, 8'h7F, 8'hC3, 8'h3C);
    fetch_pixel(10'd0, 10'd0);
    fetch_pixel(10'd1, 10'd0);
    fetch_pixel(10'd0, 10'd1);
    fetch_pixel(10'd1, 10'd1);
    fetch_pixel(10'd255, 10'd255);
    fetch_pixel(10'd256, 10'd256);
    fetch_pixel(10'd510, 10'd0);
    fetch_pixel(10'd1023, 10'd1023);
    fetch_pixel(10'd1023, 10'd0);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    settle();
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(phase_setting(p));
      run_phase(PHASE_ITEMS);
      settle();
    end
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Ends the run when nothing has been accepted for too long.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
design/bmsp_pkg.sv
design/bmsp_fold.sv
design/bayer_mosaic_symmetric_pad_unit.sv
tb/tb_bayer_mosaic_symmetric_pad_unit.sv
